### design/grpt_pkg.sv
// Package for the Gillespie reaction-pick and tau block.
// Holds shared constants and the front-to-back job record type.
`default_nettype none
package grpt_pkg;
  localparam int REACTIONS     = 64;
  localparam int TAU_FRAC_BITS = 24;
  localparam int IDX_W         = 6;
  localparam int TOT_W         = 37;
  localparam int LOG_FRAC      = 30;
  localparam int QW            = 64;
  localparam int TAU_LSB       = 40 - TAU_FRAC_BITS;
  localparam logic [31:0] TINY_RANDOM = 32'd429497;
  localparam logic [27:0] LN2_Q28     = 28'd186065280;
  localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(REACTIONS - 1);
  localparam int QDEPTH = 2;

  // One finished batch handed from front to back
  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [TOT_W-1:0] total;
    logic [31:0]      trand;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE, B_LOG, B_MUL, B_DIV, B_OUT
  } back_state_t;
endpackage
`default_nettype wire

### design/gillespie_reaction_pick_and_tau.sv
// Top level: Gillespie direct-method step, front accumulator plus tau back end.
// Depends on grpt_pkg, grpt_front, grpt_queue and grpt_back.
//
//  channel | signals                                       | dir
//  in      | in_valid/in_stall, propensity..last_reaction  | input
//  out     | out_valid/out_stall, chosen_reaction..zero    | output
//
// Front takes one propensity per cycle; batches never stall unless the queue is full.
// Back runs each batch through 30 squaring steps of the log unit, one multiply, 64
// quotient bits of the divider and one result beat; zero sum skips to result.
// Synchronous reset clears all control state; payload needs none.
// A stalled result holds the back end; the queue absorbs two further batches.
`default_nettype none
module gillespie_reaction_pick_and_tau import grpt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [30:0] propensity,
  input  wire logic [36:0] pick_value,
  input  wire logic [31:0] time_random,
  input  wire logic        last_reaction,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       chosen_reaction,
  output logic [31:0]      time_step,
  output logic             zero_total
);
  job_t f_job, b_job;
  logic f_valid, f_stall, b_valid, b_take;

  grpt_front u_front (
    .clk, .rst, .in_valid, .in_stall, .propensity, .pick_value, .time_random,
    .last_reaction, .job_valid(f_valid), .job_stall(f_stall), .job(f_job)
  );
  grpt_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_job),
    .rd_valid(b_valid), .rd_take(b_take), .rd_data(b_job)
  );
  grpt_back u_back (
    .clk, .rst, .job_valid(b_valid), .job_take(b_take), .job(b_job),
    .out_valid, .out_stall, .chosen_reaction, .time_step, .zero_total
  );

  // Zero flag always comes with a saturated tau
  a_zero_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_total |-> time_step == 32'hFFFF_FFFF)
    else $error("zero total without saturated tau");
  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(time_step))
    else $error("result changed under stall");
  // Non-last beats are never stalled
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !last_reaction |-> !in_stall)
    else $error("stall on a non-last beat");
endmodule
`default_nettype wire

### design/grpt_front.sv
// Front part: accumulates propensities and tracks the picked interval.
// Depends on grpt_pkg; emits one job per batch into the queue.
`default_nettype none
module grpt_front import grpt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [30:0] propensity,
  input  wire logic [36:0] pick_value,
  input  wire logic [31:0] time_random,
  input  wire logic        last_reaction,
  output logic             job_valid,
  input  wire logic        job_stall,
  output job_t             job
);
  logic [TOT_W-1:0] running_total;
  logic [IDX_W-1:0] selected_index;
  logic [IDX_W-1:0] item_position;
  logic [TOT_W-1:0] held_pick;
  logic [31:0]      held_time_random;
  logic             first;
  logic [TOT_W-1:0] pick, base;
  logic [31:0]      trand;
  logic [TOT_W:0]   upper;
  logic [IDX_W-1:0] idx, sel;
  logic [TOT_W-1:0] total_next;
  logic             acc;

  // Stall only while the last beat cannot enter the queue
  assign in_stall = last_reaction & job_stall;
  assign acc      = in_valid & ~in_stall;

  assign first = (item_position == '0);
  assign pick  = first ? pick_value : held_pick;
  assign trand = first ? time_random : held_time_random;
  assign base  = first ? '0 : running_total;
  assign idx   = (32'(item_position) > REACTIONS - 1) ? IDX_LAST : item_position;
  assign upper = {1'b0, base} + {7'd0, propensity};
  assign sel   = (pick > base && {1'b0, pick} <= upper) ? idx
               : (first ? '0 : selected_index);
  assign total_next = upper[TOT_W] ? TOTAL_MAX : upper[TOT_W-1:0];

  assign job_valid   = in_valid & last_reaction;
  assign job.index   = sel;
  assign job.total   = total_next;
  assign job.trand   = trand;

  // Advance batch state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      item_position <= '0;
      running_total <= '0;
      selected_index <= '0;
      held_pick <= '0;
      held_time_random <= '0;
    end else if (acc) begin
      if (last_reaction) begin
        item_position <= '0;
      end else begin
        running_total <= total_next;
        selected_index <= sel;
        held_pick <= pick;
        held_time_random <= trand;
        if (item_position != 6'd63) item_position <= item_position + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

### design/grpt_queue.sv
// Two-entry job queue between front and back parts.
// Depends on grpt_pkg for job_t.
`default_nettype none
module grpt_queue import grpt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  output logic      wr_stall,
  input  wire job_t wr_data,
  output logic      rd_valid,
  input  wire logic rd_take,
  output job_t      rd_data
);
  job_t       mem [QDEPTH];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       wr, rd;

  assign wr_stall = (cnt == 2'(QDEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_data  = mem[rp];
  assign wr = wr_valid & ~wr_stall;
  assign rd = rd_take & rd_valid;

  // Store payload
  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
  end

  // Move pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end
endmodule
`default_nettype wire

### design/grpt_back.sv
// Back part: log2 by repeated squaring, scale by ln 2, restoring divide.
// Depends on grpt_pkg; consumes jobs and drives the result channel.
`default_nettype none
module grpt_back import grpt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        job_valid,
  output logic             job_take,
  input  wire job_t        job,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       chosen_reaction,
  output logic [31:0]      time_step,
  output logic             zero_total
);
  back_state_t state, state_next;
  logic [32:0]      z;
  logic [29:0]      f;
  logic [4:0]       p;
  logic [5:0]       cnt;
  logic [TOT_W-1:0] den;
  logic [QW-1:0]    q;
  logic [TOT_W:0]   rem;
  logic [65:0]      sq;
  logic [35:0]      n;
  logic [63:0]      l;
  logic [31:0]      t;
  logic [4:0]       lead;
  logic [TOT_W:0]   trial;
  logic [QW-TAU_LSB-33:0] tau_hi;
  logic             ld, step;

  assign t = (job.trand == '0) ? TINY_RANDOM : job.trand;
  // Leading one position
  always_comb begin
    lead = '0;
    for (int i = 0; i < 32; i++) if (t[i]) lead = 5'(i);
  end

  assign sq    = 66'(z) * 66'(z);
  assign n     = (36'd32 << LOG_FRAC) - ((36'(p) << LOG_FRAC) + 36'(f));
  assign l     = 64'(n) * 64'(LN2_Q28);
  assign trial = {rem[TOT_W-1:0], q[QW-1]};

  // Sequence the job
  always_comb begin
    state_next = state;
    job_take = 1'b0;
    ld = 1'b0;
    step = 1'b0;
    case (state)
      B_IDLE: if (job_valid) begin
        job_take = 1'b1; ld = 1'b1;
        state_next = (job.total == '0) ? B_OUT : B_LOG;
      end
      B_LOG: begin
        step = 1'b1;
        if (cnt == 6'(LOG_FRAC - 1)) state_next = B_MUL;
      end
      B_MUL: state_next = B_DIV;
      B_DIV: begin
        step = 1'b1;
        if (cnt == 6'(QW - 1)) state_next = B_OUT;
      end
      B_OUT: if (!out_stall) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  // Datapath: load, squaring iterations, ln 2 scaling, then one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (ld) begin
      chosen_reaction <= job.index;
      den <= job.total;
      zero_total <= (job.total == '0);
      p <= lead;
      z <= 33'(t << (5'd31 - lead));
      f <= '0;
      cnt <= '0;
    end else if (state == B_LOG) begin
      if (sq[63]) begin
        z <= 33'(sq >> 32); f <= {f[28:0], 1'b1};
      end else begin
        z <= 33'(sq >> 31); f <= {f[28:0], 1'b0};
      end
      cnt <= (cnt == 6'(LOG_FRAC - 1)) ? '0 : cnt + 1'b1;
    end else if (state == B_MUL) begin
      q <= l >> 18;
      rem <= '0;
      cnt <= '0;
    end else if (state == B_DIV) begin
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den}; q <= {q[QW-2:0], 1'b1};
      end else begin
        rem <= trial; q <= {q[QW-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
    end
  end

  // Saturate when the total was zero or the quotient has bits above the 32-bit tau window
  assign tau_hi = q[QW-1:TAU_LSB+32];
  assign out_valid = (state == B_OUT);
  assign time_step = (zero_total || tau_hi != '0) ? 32'hFFFF_FFFF
                   : q[TAU_LSB +: 32];
endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking bench for gillespie_reaction_pick_and_tau: directed table, then random batches.
// Depends on grpt_pkg and the RTL under design/.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import grpt_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [30:0] propensity = '0;
  logic [36:0] pick_value = '0;
  logic [31:0] time_random = '0;
  logic        last_reaction = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  chosen_reaction;
  logic [31:0] time_step;
  logic        zero_total;

  gillespie_reaction_pick_and_tau dut (.*);

  typedef struct {
    logic [5:0]  idx;
    logic [31:0] tau;
    logic        zero;
  } pick_tau_t;

  typedef struct {
    logic [30:0] prop;
    logic [36:0] pick;
    logic [31:0] trand;
    logic        last;
    bit          typed;
    pick_tau_t   res;
  } row_t;

  pick_tau_t   pending_steps[$];
  int          errs = 0;

  // predictor state
  logic [36:0] sum_q;
  logic [5:0]  sel_q;
  logic [5:0]  pos_q;
  logic [36:0] pick_q;
  logic [31:0] tr_q;

  initial forever #5 clk = ~clk;

  // -ln(t / 2^32) in Q.40
  function automatic logic [63:0] neg_ln40(input logic [31:0] tin);
    logic [63:0] t, z, f, n;
    int p;
    t = (tin == 0) ? 64'(TINY_RANDOM) : 64'(tin);
    f = 0;
    p = 31;
    while (p > 0 && t[p] == 1'b0) p--;
    z = t << (31 - p);
    for (int i = 0; i < LOG_FRAC; i++) begin
      z = (z * z) >> 31;
      f = f << 1;
      if (z >= 64'h1_0000_0000) begin
        f[0] = 1'b1;
        z = z >> 1;
      end
    end
    n = (64'd32 << LOG_FRAC) - ((64'(p) << LOG_FRAC) + f);
    return (n * 64'(LN2_Q28)) >> 18;
  endfunction

  // advance the batch state by one beat; return 1 with a step when the batch closes
  function automatic bit step_batch(input logic [30:0] prop, input logic [36:0] pick,
                                    input logic [31:0] trand, input logic last,
                                    output pick_tau_t r);
    logic [63:0] upper, q, tau;
    logic [5:0]  idx;
    if (pos_q == 0) begin
      pick_q = pick;
      tr_q = trand;
      sum_q = 0;
      sel_q = 0;
    end
    idx = (pos_q > IDX_LAST) ? IDX_LAST : pos_q;
    upper = 64'(sum_q) + 64'(prop);
    if (pick_q > sum_q && 64'(pick_q) <= upper) sel_q = idx;
    sum_q = (upper > 64'(TOTAL_MAX)) ? TOTAL_MAX : upper[36:0];
    if (pos_q < 63) pos_q++;
    r = '{default: '0};
    if (!last) return 1'b0;
    r.idx = sel_q;
    if (sum_q == 0) begin
      r.tau = 32'hFFFF_FFFF;
      r.zero = 1'b1;
    end else begin
      q = neg_ln40(tr_q) / 64'(sum_q);
      tau = q >> (40 - TAU_FRAC_BITS);
      r.tau = (tau > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tau[31:0];
      r.zero = 1'b0;
    end
    sum_q = 0; sel_q = 0; pos_q = 0; pick_q = 0; tr_q = 0;
    return 1'b1;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drive one beat, wait for acceptance, then predict
  task automatic send(input row_t rw, input int gap);
    pick_tau_t r;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    propensity <= rw.prop;
    pick_value <= rw.pick;
    time_random <= rw.trand;
    last_reaction <= rw.last;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    if (step_batch(rw.prop, rw.pick, rw.trand, rw.last, r))
      pending_steps.push_back(rw.typed ? rw.res : r);
  endtask

  // result side: random stall, check each accepted beat
  int stall_left = 0;
  bit calm = 1'b0;
  always @(posedge clk) begin
    pick_tau_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_steps.size() == 0) begin
        $error("unexpected result beat idx=%0d tau=%h", chosen_reaction, time_step);
        errs++;
      end else begin
        e = pending_steps.pop_front();
        if (chosen_reaction !== e.idx) begin
          $error("chosen_reaction exp %0d got %0d", e.idx, chosen_reaction); errs++;
        end
        if (time_step !== e.tau) begin
          $error("time_step exp %h got %h", e.tau, time_step); errs++;
        end
        if (zero_total !== e.zero) begin
          $error("zero_total exp %0d got %0d", e.zero, zero_total); errs++;
        end
      end
    end
    if ($urandom_range(0, 299) == 0) calm = ~calm;
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left = gap_len();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  localparam logic [30:0] PMAX = 31'h7FFF_FFFF;
  localparam pick_tau_t ZERO_RES = '{idx: 6'd0, tau: 32'hFFFF_FFFF, zero: 1'b1};
  localparam pick_tau_t NO_RES = '{idx: 6'd0, tau: 32'd0, zero: 1'b0};

  initial begin
    row_t tbl[$];
    row_t rw;
    logic [30:0] props[$];
    logic [63:0] tot;
    int n_items, len, k;
    bit quiet;
    sum_q = 0; sel_q = 0; pos_q = 0; pick_q = 0; tr_q = 0;

    // directed rows
    tbl = '{
      '{31'd0, 37'd5, 32'd0, 1'b1, 1'b1, ZERO_RES},
      '{PMAX, {37{1'b1}}, 32'd0, 1'b1, 1'b0, NO_RES},
      '{PMAX, 37'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_RES},
      '{31'd1, 37'd1, 32'h8000_0000, 1'b1, 1'b0, NO_RES},
      '{31'd10, 37'd15, 32'd12345, 1'b0, 1'b0, NO_RES},
      '{31'd0, 37'd0, 32'd0, 1'b0, 1'b0, NO_RES},
      '{31'd20, 37'd0, 32'd0, 1'b0, 1'b0, NO_RES},
      '{31'd5, 37'd0, 32'd0, 1'b1, 1'b0, NO_RES},
      '{31'd0, 37'd7, 32'd99, 1'b0, 1'b0, NO_RES},
      '{31'd0, 37'd0, 32'd0, 1'b0, 1'b0, NO_RES},
      '{31'd0, 37'd0, 32'd0, 1'b1, 1'b1, ZERO_RES},
      '{31'd4, 37'd4, 32'h0000_0001, 1'b0, 1'b0, NO_RES},
      '{31'd4, 37'd0, 32'd0, 1'b1, 1'b0, NO_RES},
      '{31'd3, 37'd100, 32'h4000_0000, 1'b0, 1'b0, NO_RES},
      '{31'd3, 37'd0, 32'd0, 1'b1, 1'b0, NO_RES},
      '{PMAX, 37'h10_0000_0000, 32'h8000_0001, 1'b1, 1'b0, NO_RES},
      '{31'h5555_5555, 37'h0A_AAAA_AAAA, 32'hAAAA_AAAA, 1'b1, 1'b0, NO_RES},
      '{31'h2AAA_AAAA, 37'h15_5555_5555, 32'h5555_5555, 1'b1, 1'b0, NO_RES}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (tbl[i]) send(tbl[i], gap_len());

    // random batches: mostly short, a few longer than the reaction count
    n_items = 0;
    quiet = 1'b0;
    while (n_items < 1700) begin
      k = $urandom_range(0, 99);
      len = (k < 85) ? $urandom_range(1, 8) : (k < 95) ? $urandom_range(9, 40)
                                                        : $urandom_range(60, 72);
      props.delete();
      tot = 0;
      for (int i = 0; i < len; i++) begin
        k = $urandom_range(0, 9);
        props.push_back(k == 0 ? 31'd0 : k == 1 ? PMAX :
                        k < 5 ? 31'($urandom_range(0, 1000)) : 31'($urandom));
        tot += props[i];
      end
      k = $urandom_range(0, 9);
      rw.pick = (k < 7) ? 37'(({$urandom, $urandom} % (tot + 1))) :
                (k == 7) ? 37'd0 : 37'({$urandom, $urandom});
      k = $urandom_range(0, 19);
      rw.trand = (k == 0) ? 32'd0 : (k == 1) ? 32'hFFFF_FFFF : $urandom;
      rw.typed = 1'b0;
      rw.res = NO_RES;
      if ($urandom_range(0, 199) == 0) quiet = ~quiet;
      for (int i = 0; i < len; i++) begin
        rw.prop = props[i];
        rw.last = (i == len - 1);
        send(rw, quiet ? 0 : gap_len());
        rw.pick = 37'({$urandom, $urandom});
        rw.trand = $urandom;
      end
      n_items += len;
    end
    in_valid <= 1'b0;

    // drain
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errs == 0 && pending_steps.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
